### sv/tcac_pkg.sv
// tcac_pkg: shared widths, payload types and helper functions for the
// triangle corner angle check pipeline; no dependencies
package tcac_pkg;

  // field widths
  localparam int CoordW    = 16;
  localparam int TagW      = 20;
  localparam int ThrW      = 16;
  localparam int CornerW   = 2;
  localparam int NumCorner = 3;
  localparam int NumAxis   = 3;

  // datapath widths
  localparam int EdgeW     = CoordW + 1;          // vertex difference
  localparam int ProdW     = 2 * EdgeW;           // one component product
  localparam int LenW      = 2 * EdgeW;           // squared edge length
  localparam int DotW      = 2 * EdgeW + 1;       // signed dot product
  localparam int MagW      = 2 * EdgeW;           // dot product magnitude
  localparam int HalfW     = MagW / 2;            // multiplier operand slice
  localparam int PpW       = 2 * HalfW;           // slice partial product
  localparam int SqW       = 2 * MagW;            // dot^2 and len*len
  localparam int ThrProdW  = 2 * ThrW;
  localparam int ThrSqW    = 2 * ThrW - 1;        // threshold squared, up to 2^30
  localparam int NumChunk  = SqW / HalfW;
  localparam int RpW       = ThrSqW + HalfW;      // threshold times one slice
  localparam int RhsW      = SqW + ThrSqW;        // compare width
  localparam int FracShift = 2 * (ThrW - 1);      // Q1.15 squared scale

  localparam logic [CornerW-1:0] CornerNone = 2'd3;

  localparam logic signed [ThrW-1:0] ThrReset = 16'sh7fff;
  localparam logic [ThrSqW-1:0] ThrSqReset = ThrSqW'(int'(ThrReset) * int'(ThrReset));

  // input beat
  typedef struct packed {
    logic [TagW-1:0]          tri_tag;
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } tcac_in_t;

  // output beat
  typedef struct packed {
    logic [TagW-1:0]    out_tag;
    logic               is_bad;
    logic [CornerW-1:0] bad_corner;
  } tcac_out_t;

  // edge lengths (per edge) and dot products (per corner, two's complement)
  typedef struct packed {
    logic [TagW-1:0]                 tag;
    logic [NumCorner-1:0][LenW-1:0]  len;
    logic [NumCorner-1:0][DotW-1:0]  dot;
  } geo_t;

  // per corner compare operands
  typedef struct packed {
    logic            zero_len;
    logic            dot_neg;
    logic [SqW-1:0]  lhs;        // dot^2, scale applied at the compare
    logic [RhsW-1:0] rhs;        // thr^2 * |a|^2 * |b|^2
  } corner_t;

  typedef struct packed {
    logic [TagW-1:0]               tag;
    corner_t [NumCorner-1:0]       corner;
  } prod_t;

  // unsigned slice multiply
  function automatic logic [PpW-1:0] mul_half(input logic [HalfW-1:0] a,
                                              input logic [HalfW-1:0] b);
    return PpW'(a) * PpW'(b);
  endfunction

  // square of the threshold magnitude
  function automatic logic [ThrSqW-1:0] thr_square(input logic signed [ThrW-1:0] t);
    logic [ThrW-1:0]     m;
    logic [ThrProdW-1:0] s;
    m = t[ThrW-1] ? ThrW'(-t) : ThrW'(t);
    s = ThrProdW'(m) * ThrProdW'(m);
    return s[ThrSqW-1:0];
  endfunction

endpackage

### sv/tcac_edge_prod.sv
// tcac_edge_prod: three pipeline stages forming edges, component products
// and per edge lengths / per corner dot products; depends on tcac_pkg
module tcac_edge_prod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcac_pkg::tcac_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcac_pkg::geo_t     out_data_o
);

  localparam int NumStage = 3;

  logic [NumStage-1:0] vld_q;
  logic [NumStage-1:0] en;

  logic signed [tcac_pkg::CoordW-1:0] vtx [tcac_pkg::NumCorner][tcac_pkg::NumAxis];

  logic [tcac_pkg::TagW-1:0]         tag1_q, tag2_q;
  logic signed [tcac_pkg::EdgeW-1:0] edge_d [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  logic signed [tcac_pkg::EdgeW-1:0] edge_q [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  logic signed [tcac_pkg::ProdW-1:0] sq_d   [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  logic signed [tcac_pkg::ProdW-1:0] sq_q   [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  logic signed [tcac_pkg::ProdW-1:0] dp_d   [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  logic signed [tcac_pkg::ProdW-1:0] dp_q   [tcac_pkg::NumCorner][tcac_pkg::NumAxis];
  tcac_pkg::geo_t                    geo_d, geo_q;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[2] = !vld_q[2] || out_ready_i;
    en[1] = !vld_q[1] || en[2];
    en[0] = !vld_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[2];
  assign out_data_o  = geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  // vertex table
  always_comb begin
    vtx[0][0] = in_data_i.v0_x;
    vtx[0][1] = in_data_i.v0_y;
    vtx[0][2] = in_data_i.v0_z;
    vtx[1][0] = in_data_i.v1_x;
    vtx[1][1] = in_data_i.v1_y;
    vtx[1][2] = in_data_i.v1_z;
    vtx[2][0] = in_data_i.v2_x;
    vtx[2][1] = in_data_i.v2_y;
    vtx[2][2] = in_data_i.v2_z;
  end

  // stage 1: edge i runs from vertex i to the next vertex
  always_comb begin
    for (int i = 0; i < tcac_pkg::NumCorner; i++) begin
      for (int k = 0; k < tcac_pkg::NumAxis; k++) begin
        edge_d[i][k] = tcac_pkg::EdgeW'(vtx[(i == tcac_pkg::NumCorner-1) ? 0 : i+1][k])
                     - tcac_pkg::EdgeW'(vtx[i][k]);
      end
    end
  end

  // stage 2: squares per edge, dot terms per corner (incoming edge is the previous one)
  always_comb begin
    for (int i = 0; i < tcac_pkg::NumCorner; i++) begin
      for (int k = 0; k < tcac_pkg::NumAxis; k++) begin
        sq_d[i][k] = tcac_pkg::ProdW'(edge_q[i][k]) * tcac_pkg::ProdW'(edge_q[i][k]);
        dp_d[i][k] = tcac_pkg::ProdW'(edge_q[(i == 0) ? tcac_pkg::NumCorner-1 : i-1][k])
                   * tcac_pkg::ProdW'(edge_q[i][k]);
      end
    end
  end

  // stage 3: component sums
  always_comb begin
    geo_d.tag = tag2_q;
    for (int i = 0; i < tcac_pkg::NumCorner; i++) begin
      geo_d.len[i] = tcac_pkg::LenW'($unsigned(sq_q[i][0]))
                   + tcac_pkg::LenW'($unsigned(sq_q[i][1]))
                   + tcac_pkg::LenW'($unsigned(sq_q[i][2]));
      geo_d.dot[i] = tcac_pkg::DotW'(dp_q[i][0])
                   + tcac_pkg::DotW'(dp_q[i][1])
                   + tcac_pkg::DotW'(dp_q[i][2]);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tag1_q <= in_data_i.tri_tag;
      edge_q <= edge_d;
    end
    if (en[1]) begin
      tag2_q <= tag1_q;
      sq_q   <= sq_d;
      dp_q   <= dp_d;
    end
    if (en[2]) begin
      geo_q <= geo_d;
    end
  end

`ifndef SYNTHESIS
  // a held middle stage keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !en[2] |=> vld_q[1] && $stable(tag2_q))
    else $error("tcac_edge_prod: stalled stage lost its beat");
`endif

endmodule

### sv/tcac_wide_mul.sv
// tcac_wide_mul: five pipeline stages building dot^2 and thr^2*|a|^2*|b|^2
// from sliced partial products; depends on tcac_pkg
module tcac_wide_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tcac_pkg::geo_t                   in_data_i,
  input  logic [tcac_pkg::ThrSqW-1:0]      thr_sq_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tcac_pkg::prod_t                  out_data_o
);

  localparam int NumStage = 5;

  typedef struct packed {
    logic [tcac_pkg::TagW-1:0]      tag;
    logic [tcac_pkg::NumCorner-1:0] zero_len;
    logic [tcac_pkg::NumCorner-1:0] dot_neg;
  } side_t;

  logic [NumStage-1:0] vld_q;
  logic [NumStage-1:0] en;

  side_t side_d;
  side_t side_q [NumStage-1];

  logic [tcac_pkg::MagW-1:0]  ad_d [tcac_pkg::NumCorner], ad_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::LenW-1:0]  la_d [tcac_pkg::NumCorner], la_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::LenW-1:0]  lb_d [tcac_pkg::NumCorner], lb_q [tcac_pkg::NumCorner];
  logic signed [tcac_pkg::DotW-1:0] dv;

  logic [tcac_pkg::PpW-1:0] phh_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] phl_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] pll_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] qhh_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] qhl_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] qlh_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::PpW-1:0] qll_q [tcac_pkg::NumCorner];

  logic [tcac_pkg::SqW-1:0] sqd_d [tcac_pkg::NumCorner], sqd_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::SqW-1:0] sql_d [tcac_pkg::NumCorner], sql_q [tcac_pkg::NumCorner];
  logic [tcac_pkg::SqW-1:0] sqd4_q [tcac_pkg::NumCorner];

  logic [tcac_pkg::RpW-1:0] rp_d [tcac_pkg::NumCorner][tcac_pkg::NumChunk];
  logic [tcac_pkg::RpW-1:0] rp_q [tcac_pkg::NumCorner][tcac_pkg::NumChunk];

  logic [tcac_pkg::RhsW-1:0] rhs_acc;
  tcac_pkg::prod_t           out_d, out_q;

  // stage enables, back to front
  always_comb begin
    en[NumStage-1] = !vld_q[NumStage-1] || out_ready_i;
    for (int k = NumStage-2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStage-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStage; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: dot magnitude and sign, edge pair per corner, zero length flag
  always_comb begin
    side_d.tag = in_data_i.tag;
    dv = '0;
    for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
      dv = $signed(in_data_i.dot[p]);
      side_d.dot_neg[p] = dv[tcac_pkg::DotW-1];
      ad_d[p] = dv[tcac_pkg::DotW-1] ? tcac_pkg::MagW'(-dv) : tcac_pkg::MagW'(dv);
      la_d[p] = in_data_i.len[(p == 0) ? tcac_pkg::NumCorner-1 : p-1];
      lb_d[p] = in_data_i.len[p];
      side_d.zero_len[p] = (la_d[p] == '0) || (lb_d[p] == '0);
    end
  end

  // stage 3: recombine slice products
  always_comb begin
    for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
      sqd_d[p] = (tcac_pkg::SqW'(phh_q[p]) << tcac_pkg::PpW)
               + (tcac_pkg::SqW'(phl_q[p]) << (tcac_pkg::HalfW + 1))
               + tcac_pkg::SqW'(pll_q[p]);
      sql_d[p] = (tcac_pkg::SqW'(qhh_q[p]) << tcac_pkg::PpW)
               + (tcac_pkg::SqW'(qhl_q[p]) << tcac_pkg::HalfW)
               + (tcac_pkg::SqW'(qlh_q[p]) << tcac_pkg::HalfW)
               + tcac_pkg::SqW'(qll_q[p]);
    end
  end

  // stage 4: threshold square times each slice of the length product
  always_comb begin
    for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
      for (int k = 0; k < tcac_pkg::NumChunk; k++) begin
        rp_d[p][k] = tcac_pkg::RpW'(thr_sq_i)
                   * tcac_pkg::RpW'(sql_q[p][tcac_pkg::HalfW*k +: tcac_pkg::HalfW]);
      end
    end
  end

  // stage 5: sum the slices into the right hand side
  always_comb begin
    out_d.tag = side_q[3].tag;
    rhs_acc   = '0;
    for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
      rhs_acc = '0;
      for (int k = 0; k < tcac_pkg::NumChunk; k++) begin
        rhs_acc = rhs_acc + (tcac_pkg::RhsW'(rp_q[p][k]) << (tcac_pkg::HalfW * k));
      end
      out_d.corner[p].zero_len = side_q[3].zero_len[p];
      out_d.corner[p].dot_neg  = side_q[3].dot_neg[p];
      out_d.corner[p].lhs      = sqd4_q[p];
      out_d.corner[p].rhs      = rhs_acc;
    end
  end

  // payload registers; stage 2 is the slice multipliers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
      ad_q      <= ad_d;
      la_q      <= la_d;
      lb_q      <= lb_d;
    end
    if (en[1]) begin
      side_q[1] <= side_q[0];
      for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
        phh_q[p] <= tcac_pkg::mul_half(ad_q[p][tcac_pkg::MagW-1:tcac_pkg::HalfW],
                                       ad_q[p][tcac_pkg::MagW-1:tcac_pkg::HalfW]);
        phl_q[p] <= tcac_pkg::mul_half(ad_q[p][tcac_pkg::MagW-1:tcac_pkg::HalfW],
                                       ad_q[p][tcac_pkg::HalfW-1:0]);
        pll_q[p] <= tcac_pkg::mul_half(ad_q[p][tcac_pkg::HalfW-1:0],
                                       ad_q[p][tcac_pkg::HalfW-1:0]);
        qhh_q[p] <= tcac_pkg::mul_half(la_q[p][tcac_pkg::LenW-1:tcac_pkg::HalfW],
                                       lb_q[p][tcac_pkg::LenW-1:tcac_pkg::HalfW]);
        qhl_q[p] <= tcac_pkg::mul_half(la_q[p][tcac_pkg::LenW-1:tcac_pkg::HalfW],
                                       lb_q[p][tcac_pkg::HalfW-1:0]);
        qlh_q[p] <= tcac_pkg::mul_half(la_q[p][tcac_pkg::HalfW-1:0],
                                       lb_q[p][tcac_pkg::LenW-1:tcac_pkg::HalfW]);
        qll_q[p] <= tcac_pkg::mul_half(la_q[p][tcac_pkg::HalfW-1:0],
                                       lb_q[p][tcac_pkg::HalfW-1:0]);
      end
    end
    if (en[2]) begin
      side_q[2] <= side_q[1];
      sqd_q     <= sqd_d;
      sql_q     <= sql_d;
    end
    if (en[3]) begin
      side_q[3] <= side_q[2];
      sqd4_q    <= sqd_q;
      rp_q      <= rp_d;
    end
    if (en[4]) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // a zero length edge can only come with a zero dot product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && side_q[0].zero_len[0] |-> ad_q[0] == '0)
    else $error("tcac_wide_mul: zero length edge with nonzero dot product");
`endif

endmodule

### sv/tcac_corner_cmp.sv
// tcac_corner_cmp: final stage, per corner compare with sign handling and
// first failing corner select into the output register; depends on tcac_pkg
module tcac_corner_cmp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tcac_pkg::prod_t                   in_data_i,
  input  logic signed [tcac_pkg::ThrW-1:0]  thr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcac_pkg::tcac_out_t               out_data_o
);

  logic                           vld_q;
  logic                           en;
  logic                           thr_nonpos;
  logic [tcac_pkg::RhsW-1:0]      lhs_w;
  logic [tcac_pkg::NumCorner-1:0] fail;
  tcac_pkg::tcac_out_t            out_d, out_q;

  assign en          = !vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  // corner test: zero length edge means cosine 0, else signs first, then magnitudes
  always_comb begin
    thr_nonpos = thr_i[tcac_pkg::ThrW-1] || (thr_i == '0);
    lhs_w      = '0;
    for (int p = 0; p < tcac_pkg::NumCorner; p++) begin
      lhs_w = tcac_pkg::RhsW'(in_data_i.corner[p].lhs) << tcac_pkg::FracShift;
      if (in_data_i.corner[p].zero_len) begin
        fail[p] = thr_nonpos;
      end else if (!in_data_i.corner[p].dot_neg && thr_nonpos) begin
        fail[p] = 1'b1;
      end else if (in_data_i.corner[p].dot_neg && !thr_nonpos) begin
        fail[p] = 1'b0;
      end else if (!in_data_i.corner[p].dot_neg) begin
        fail[p] = lhs_w >= in_data_i.corner[p].rhs;
      end else begin
        fail[p] = lhs_w <= in_data_i.corner[p].rhs;
      end
    end
  end

  // first failing corner wins
  always_comb begin
    out_d.out_tag = in_data_i.tag;
    out_d.is_bad  = |fail;
    if (fail[0]) begin
      out_d.bad_corner = 2'd0;
    end else if (fail[1]) begin
      out_d.bad_corner = 2'd1;
    end else if (fail[2]) begin
      out_d.bad_corner = 2'd2;
    end else begin
      out_d.bad_corner = tcac_pkg::CornerNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // flag and corner code agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_bad == (out_data_o.bad_corner != tcac_pkg::CornerNone)))
    else $error("tcac_corner_cmp: is_bad does not match bad_corner");
`endif

endmodule

### sv/triangle_corner_angle_check_core.sv
// triangle_corner_angle_check_core: top level, threshold register and the
// nine stage check pipeline; depends on tcac_pkg, tcac_edge_prod,
// tcac_wide_mul and tcac_corner_cmp
//
// Usage:
//   Input beats (in_valid_i / in_ready_o, in_data_i) carry one triangle: a tag
//   and three vertices of signed 16-bit coordinates. Output beats (out_valid_o /
//   out_ready_i, out_data_o) carry the tag, is_bad and the first corner whose
//   cosine between incoming and outgoing edge reaches the threshold (3 if none).
//   One output beat per input beat, in order.
//   The threshold (signed Q1.15 cosine) is written with cfg_we_i / cfg_wdata_i
//   while no triangle is in flight; it applies to triangles accepted after the
//   write, through the registered threshold and its registered square.
//   Throughput: one triangle per cycle unless out_ready_i stalls the pipe, which
//   has nine register stages (three for edges and sums, five for the sliced wide
//   products, one compare).
//   Stalls: each stage moves when it is empty or its successor moves, so empty
//   stages fill up under a stalled receiver; in_ready_o drops only when all nine
//   stages hold a beat and out_ready_i is low.
//   Reset: pipeline empty, threshold 32767.
module triangle_corner_angle_check_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tcac_pkg::tcac_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tcac_pkg::tcac_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tcac_pkg::ThrW-1:0]       cfg_wdata_i
);

  logic signed [tcac_pkg::ThrW-1:0] thr_q, thr_d;
  logic [tcac_pkg::ThrSqW-1:0]      thr_sq_q, thr_sq_d;

  logic            geo_valid, geo_ready;
  tcac_pkg::geo_t  geo_data;
  logic            prod_valid, prod_ready;
  tcac_pkg::prod_t prod_data;

  // threshold register and its square
  assign thr_d    = cfg_we_i ? $signed(cfg_wdata_i) : thr_q;
  assign thr_sq_d = tcac_pkg::thr_square(thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= tcac_pkg::ThrReset;
      thr_sq_q <= tcac_pkg::ThrSqReset;
    end else begin
      thr_q    <= thr_d;
      thr_sq_q <= thr_sq_d;
    end
  end

  // edges, products and sums
  tcac_edge_prod u_edge_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (geo_valid),
    .out_ready_i (geo_ready),
    .out_data_o  (geo_data)
  );

  // wide products
  tcac_wide_mul u_wide_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geo_valid),
    .in_ready_o  (geo_ready),
    .in_data_i   (geo_data),
    .thr_sq_i    (thr_sq_q),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_data_o  (prod_data)
  );

  // compare and corner select
  tcac_corner_cmp u_corner_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_data_i   (prod_data),
    .thr_i       (thr_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // the squared threshold follows the threshold in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> thr_sq_q == tcac_pkg::thr_square(thr_q))
    else $error("triangle_corner_angle_check_core: threshold square out of date");
`endif

`ifndef SYNTHESIS
  // input back-pressure only with a full pipe and a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("triangle_corner_angle_check_core: input stalled with room in the pipe");
`endif

endmodule
